// ===== rtl/bpsm_pkg.sv =====
`default_nettype none

package bpsm_pkg;

   // Field and register widths
   localparam int DATA_W      = 8;
   localparam int POS_W       = 40;
   localparam int TOTAL_W     = 32;
   localparam int PAT_WORD_W  = 64;
   localparam int PAT_BYTES   = 16;
   localparam int PAT_W       = 2 * PAT_WORD_W;
   localparam int PAT_SEL_W   = $clog2(PAT_BYTES);
   localparam int LEN_W       = 5;
   localparam int CSR_IDX_W   = 2;

   localparam int DEFAULT_MAX_PATTERN_BYTES = 16;

   // ASCII upper case range and the offset to lower case
   localparam logic [DATA_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [DATA_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [DATA_W-1:0] ASCII_CASE_OFS = 8'h20;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_BYTES_USED   = 2'd2,
      CSR_CASE_FOLD    = 2'd3
   } csr_index_type;

   // Control handed to every window cell
   typedef struct packed {
      logic             shift;
      logic             clear;
      logic             fold;
      logic [LEN_W-1:0] len;
   } cell_ctrl_type;

   function automatic logic [DATA_W-1:0] fold_byte(input logic [DATA_W-1:0] b,
                                                  input logic fold);
      logic [DATA_W-1:0] r;
      r = b;
      if (fold && (b >= ASCII_UPPER_A) && (b <= ASCII_UPPER_Z))
         r = b + ASCII_CASE_OFS;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bpsm_cell.sv =====
`default_nettype none

module bpsm_cell
   import bpsm_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [DATA_W-1:0]   shift_in,
   input  wire logic [PAT_W-1:0]    pattern,
   output logic      [DATA_W-1:0]   byte_out,
   output logic                     match_ok
);

   localparam logic [LEN_W-1:0] CELL_POS = LEN_W'(CELL_INDEX);

   logic [DATA_W-1:0] byte_ff;
   logic [DATA_W-1:0] byte_in;
   logic              active;
   logic [LEN_W-1:0]  sel_full;
   logic [PAT_SEL_W-1:0] sel;
   logic [DATA_W-1:0] pat_byte;

   // Pick the pattern byte that lines up with this window slot
   always_comb begin
      active   = CELL_POS < ctrl.len;
      sel_full = ctrl.len - LEN_W'(1) - CELL_POS;
      sel      = sel_full[PAT_SEL_W-1:0];
      pat_byte = pattern[{sel, 3'b000} +: DATA_W];
      match_ok = !active ||
                 (fold_byte(shift_in, ctrl.fold) == fold_byte(pat_byte, ctrl.fold));
   end

   // Advance the window, drop it at end of stream
   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear)
         byte_in = '0;
      else if (ctrl.shift)
         byte_in = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset)
         byte_ff <= '0;
      else
         byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/byte_pattern_stream_matcher.sv =====
`default_nettype none
// Latency: a result is valid in the cycle after its byte is accepted.
// One byte per cycle when not stalled; every window cell compares in parallel in the
// accept cycle, and the output register takes the next byte in the cycle its result leaves.
// Reset (synchronous, active high) clears the window, the counters and the result valid
// flag, and loads the register reset values (pattern zero, length 1, no folding).

module byte_pattern_stream_matcher
   import bpsm_pkg::*;
#(
   parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PAT_WORD_W-1:0] csr_data,
   // byte stream
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [DATA_W-1:0]     req_data_byte,
   input  wire logic                  req_end_of_stream,
   // results
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_match_found,
   output logic      [POS_W-1:0]      rsp_match_offset,
   output logic      [TOTAL_W-1:0]    rsp_match_total
);

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

   // Configuration registers
   logic [PAT_WORD_W-1:0] pat_low_ff, pat_high_ff;
   logic [LEN_W-1:0]      len_cfg_ff;
   logic                  fold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         len_cfg_ff  <= LEN_W'(1);
         fold_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_BYTES_USED:   len_cfg_ff  <= csr_data[LEN_W-1:0];
            CSR_CASE_FOLD:    fold_ff     <= csr_data[0];
         endcase
      end
   end

   // Clamp the pattern length into 1..MAX_PATTERN_BYTES
   logic [LEN_W-1:0] len;
   always_comb begin
      len = len_cfg_ff;
      if (len_cfg_ff == '0)
         len = LEN_W'(1);
      else if (len_cfg_ff > MAX_LEN)
         len = MAX_LEN;
   end

   // Handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Window cells
   cell_ctrl_type     ctrl;
   logic [PAT_W-1:0]  pattern;
   logic [DATA_W-1:0] cell_byte [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] cell_ok;

   assign pattern    = {pat_high_ff, pat_low_ff};
   assign ctrl.shift = accept;
   assign ctrl.clear = accept && req_end_of_stream;
   assign ctrl.fold  = fold_ff;
   assign ctrl.len   = len;

   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cell
      logic [DATA_W-1:0] feed;
      if (i == 0) begin : g_head
         assign feed = req_data_byte;
      end else begin : g_link
         assign feed = cell_byte[i-1];
      end
      bpsm_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .shift_in (feed),
         .pattern  (pattern),
         .byte_out (cell_byte[i]),
         .match_ok (cell_ok[i])
      );
   end

   // Stream counters
   logic [POS_W-1:0]   bytes_seen_ff, bytes_seen_in;
   logic [TOTAL_W-1:0] matches_seen_ff, matches_seen_in;
   logic [TOTAL_W-1:0] total_next;
   logic [LEN_W-1:0]   len_m1;
   logic               pos_ok;
   logic               hit;
   logic [POS_W-1:0]   offset;

   always_comb begin
      len_m1     = len - LEN_W'(1);
      pos_ok     = bytes_seen_ff >= POS_W'(len_m1);
      hit        = pos_ok && (&cell_ok);
      offset     = hit ? (bytes_seen_ff - POS_W'(len_m1)) : '0;
      total_next = matches_seen_ff;
      if (hit && (matches_seen_ff != '1))
         total_next = matches_seen_ff + TOTAL_W'(1);

      bytes_seen_in   = bytes_seen_ff;
      matches_seen_in = matches_seen_ff;
      if (accept) begin
         if (req_end_of_stream) begin
            bytes_seen_in   = '0;
            matches_seen_in = '0;
         end else begin
            matches_seen_in = total_next;
            if (bytes_seen_ff != '1)
               bytes_seen_in = bytes_seen_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff   <= '0;
         matches_seen_ff <= '0;
      end else begin
         bytes_seen_ff   <= bytes_seen_in;
         matches_seen_ff <= matches_seen_in;
      end
   end

   // Result register: load on accept, hold while stalled
   logic               found_ff;
   logic [POS_W-1:0]   offset_ff;
   logic [TOTAL_W-1:0] total_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff  <= hit;
         offset_ff <= offset;
         total_ff  <= total_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = found_ff;
   assign rsp_match_offset = offset_ff;
   assign rsp_match_total  = total_ff;

endmodule

`default_nettype wire

// ===== dv/pattern_match_checker.sv =====
module pattern_match_checker
   import bpsm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PAT_WORD_W-1:0] csr_data,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [DATA_W-1:0]     req_data_byte,
   input  wire logic                  req_end_of_stream,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  rsp_match_found,
   input  wire logic [POS_W-1:0]      rsp_match_offset,
   input  wire logic [TOTAL_W-1:0]    rsp_match_total,
   output int                         fail_count,
   output int                         waiting_results,
   output int                         bytes_checked,
   output int                         hits_checked
);

   typedef struct packed {
      logic               found;
      logic [POS_W-1:0]   offset;
      logic [TOTAL_W-1:0] total;
   } match_result_type;

   // Register copies
   logic [PAT_WORD_W-1:0] pat_lo;
   logic [PAT_WORD_W-1:0] pat_hi;
   logic [LEN_W-1:0]      pat_used;
   logic                  fold_on;

   // Stream state: raw window, newest byte at slot 0
   logic [DATA_W-1:0]     window [PAT_BYTES];
   logic [POS_W-1:0]      stream_pos;
   logic [TOTAL_W-1:0]    stream_hits;

   match_result_type      expected_matches [$];
   int                    errors = 0;
   int                    scanned = 0;
   int                    hits = 0;

   function automatic logic [DATA_W-1:0] lower_case(input logic [DATA_W-1:0] c,
                                                    input logic on);
      if (on && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
         return c + ASCII_CASE_OFS;
      return c;
   endfunction

   // Zero compares as one byte, oversized lengths stop at the window size
   function automatic int effective_length(input logic [LEN_W-1:0] n);
      int cap;
      cap = (DEFAULT_MAX_PATTERN_BYTES > PAT_BYTES) ? PAT_BYTES : DEFAULT_MAX_PATTERN_BYTES;
      if (n == 0)
         return 1;
      if (n > cap)
         return cap;
      return int'(n);
   endfunction

   task automatic clear_stream();
      for (int i = 0; i < PAT_BYTES; i++)
         window[i] = '0;
      stream_pos  = '0;
      stream_hits = '0;
   endtask

   // Shift one byte in, compare the newest bytes with the pattern, bump counters
   task automatic scan_byte(input logic [DATA_W-1:0] b, input logic eos,
                            output match_result_type r);
      int             len;
      logic [PAT_W-1:0] pat;
      logic           hit;
      len = effective_length(pat_used);
      pat = {pat_hi, pat_lo};
      for (int i = PAT_BYTES - 1; i > 0; i--)
         window[i] = window[i-1];
      window[0] = b;
      hit = 1'b0;
      if (stream_pos >= POS_W'(len - 1)) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++)
            if (lower_case(window[len-1-i], fold_on) != lower_case(pat[i*8 +: 8], fold_on))
               hit = 1'b0;
      end
      r.found  = hit;
      r.offset = hit ? stream_pos - POS_W'(len - 1) : '0;
      if (hit && stream_hits != '1)
         stream_hits++;
      if (stream_pos != '1)
         stream_pos++;
      r.total = stream_hits;
      // end of stream clears after the result is formed
      if (eos)
         clear_stream();
   endtask

   task automatic flag_field(input string field, input logic [63:0] want,
                             input logic [63:0] seen);
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, seen);
   endtask

   always @(posedge clock) begin
      match_result_type predicted;
      match_result_type oldest;
      match_result_type got;
      if (reset) begin
         pat_lo   = '0;
         pat_hi   = '0;
         pat_used = LEN_W'(1);
         fold_on  = 1'b0;
         clear_stream();
         expected_matches.delete();
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_LOW:  pat_lo = csr_data;
               CSR_PATTERN_HIGH: pat_hi = csr_data;
               CSR_BYTES_USED:   pat_used = csr_data[LEN_W-1:0];
               CSR_CASE_FOLD:    fold_on = csr_data[0];
               default: ;
            endcase
         end
         // predict each accepted item
         if (req_valid && req_ready) begin
            scan_byte(req_data_byte, req_end_of_stream, predicted);
            expected_matches.push_back(predicted);
            scanned++;
            if (predicted.found)
               hits++;
         end
         // compare each accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = '{found: rsp_match_found, offset: rsp_match_offset, total: rsp_match_total};
            if (expected_matches.size() == 0) begin
               errors++;
               $display({"%0t: unexpected result, expected none, ",
                         "got found %0d offset %0d total %0d"},
                        $time, got.found, got.offset, got.total);
            end else begin
               oldest = expected_matches.pop_front();
               if (got.found !== oldest.found)
                  flag_field("match_found", 64'(oldest.found), 64'(got.found));
               if (got.offset !== oldest.offset)
                  flag_field("match_offset", 64'(oldest.offset), 64'(got.offset));
               if (got.total !== oldest.total)
                  flag_field("match_total", 64'(oldest.total), 64'(got.total));
            end
         end
      end
      waiting_results <= expected_matches.size();
      fail_count      <= errors;
      bytes_checked   <= scanned;
      hits_checked    <= hits;
   end

endmodule

// ===== dv/tb_byte_pattern_stream_matcher.sv =====
module tb_byte_pattern_stream_matcher;
   import bpsm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 150;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [PAT_WORD_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_data_byte = '0;
   logic                  req_end_of_stream = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_match_found;
   logic [POS_W-1:0]      rsp_match_offset;
   logic [TOTAL_W-1:0]    rsp_match_total;

   int fail_count;
   int waiting_results;
   int bytes_checked;
   int hits_checked;

   int gap_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int settings_count = 0;
   int eff_len = 1;

   logic [DATA_W-1:0] pat [PAT_BYTES];
   // letters of both cases plus the characters just outside the letter ranges
   logic [DATA_W-1:0] char_set [8] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h40, 8'h5B, 8'h60, 8'h7B};

   byte_pattern_stream_matcher uut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_found   (rsp_match_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_total   (rsp_match_total)
   );

   pattern_match_checker match_check (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_found   (rsp_match_found),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_total   (rsp_match_total),
      .fail_count        (fail_count),
      .waiting_results   (waiting_results),
      .bytes_checked     (bytes_checked),
      .hits_checked      (hits_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("byte_pattern_stream_matcher test failed");
         $finish;
      end
   end

   // Offer one item, with a random gap first; valid stays high across back-to-back items
   task automatic send_byte(input logic [DATA_W-1:0] b, input logic eos);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (waiting_results != 0);
   endtask

   // Write all four registers from pat[] while the block is idle
   task automatic set_pattern(input int used_raw, input logic fold);
      logic [PAT_W-1:0]      words;
      logic [PAT_WORD_W-1:0] value [4];
      logic [PAT_WORD_W-1:0] junk;
      csr_index_type         idx;
      for (int k = 0; k < PAT_BYTES; k++)
         words[k*8 +: 8] = pat[k];
      value[CSR_PATTERN_LOW]  = words[PAT_WORD_W-1:0];
      value[CSR_PATTERN_HIGH] = words[PAT_W-1:PAT_WORD_W];
      value[CSR_BYTES_USED]   = PAT_WORD_W'(used_raw);
      value[CSR_CASE_FOLD]    = PAT_WORD_W'(fold);
      // upper bits beyond the register width must be dropped
      if ($urandom_range(1)) begin
         junk = {$urandom, $urandom};
         value[CSR_BYTES_USED][PAT_WORD_W-1:LEN_W] = junk[PAT_WORD_W-1:LEN_W];
         junk = {$urandom, $urandom};
         value[CSR_CASE_FOLD][PAT_WORD_W-1:1]      = junk[PAT_WORD_W-1:1];
      end
      idx = CSR_PATTERN_LOW;
      csr_valid <= 1'b1;
      repeat (4) begin
         csr_index <= idx;
         csr_data  <= value[idx];
         do @(posedge clock); while (!csr_ready);
         idx = idx.next();
      end
      csr_valid <= 1'b0;
      eff_len = (used_raw == 0) ? 1 : (used_raw > PAT_BYTES ? PAT_BYTES : used_raw);
      settings_count++;
   endtask

   function automatic logic is_letter(input logic [DATA_W-1:0] c);
      return ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A);
   endfunction

   initial begin
      int               sent;
      int               r;
      int               used_raw;
      logic             fold;
      logic             wide_bytes;
      logic [DATA_W-1:0] b;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single zero byte pattern
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      // zero pattern of four: short stream first, then overlapping hits
      drain();
      for (int k = 0; k < PAT_BYTES; k++)
         pat[k] = (k < 4) ? 8'h00 : DATA_W'($urandom);
      set_pattern(4, 1'b0);
      for (int k = 0; k < 5; k++)
         send_byte(8'h00, k == 4);

      // length zero acts as one; folding matches either case
      drain();
      for (int k = 0; k < PAT_BYTES; k++)
         pat[k] = DATA_W'($urandom);
      pat[0] = 8'h5A;
      set_pattern(0, 1'b1);
      send_byte(8'h7A, 1'b0);
      send_byte(8'h5B, 1'b0);
      send_byte(8'h5A, 1'b1);

      // oversized length saturates to a full window
      drain();
      for (int k = 0; k < PAT_BYTES; k++)
         pat[k] = 8'hFF;
      set_pattern(31, 1'b0);
      for (int k = 0; k < PAT_BYTES; k++)
         send_byte(8'hFF, k == PAT_BYTES - 1);

      // random phases: well-formed pattern copies with case flips, plus noise
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 55; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 55; end
            default: begin gap_pct = 7; stall_pct = 7; end
         endcase
         r = $urandom_range(9);
         case (r)
            0: used_raw = 1;
            1: used_raw = PAT_BYTES;
            2: used_raw = 0;
            3: used_raw = $urandom_range(31, PAT_BYTES + 1);
            default: used_raw = $urandom_range(8, 2);
         endcase
         fold       = 1'($urandom_range(1));
         wide_bytes = ($urandom_range(3) == 0);
         for (int k = 0; k < PAT_BYTES; k++)
            pat[k] = wide_bytes ? DATA_W'($urandom) : char_set[$urandom_range(7)];
         set_pattern(used_raw, fold);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 55) begin
               for (int k = 0; k < eff_len; k++) begin
                  b = pat[k];
                  if (is_letter(b) && $urandom_range(3) == 0)
                     b = b ^ 8'h20;
                  send_byte(b, $urandom_range(63) == 0);
                  sent++;
               end
            end else if (r < 90) begin
               repeat ($urandom_range(3, 1)) begin
                  send_byte(char_set[$urandom_range(7)], $urandom_range(63) == 0);
                  sent++;
               end
            end else begin
               send_byte(DATA_W'($urandom), $urandom_range(63) == 0);
               sent++;
            end
         end
      end

      // settle: all results back, then an idle margin before the summary
      drain();
      repeat (4) @(posedge clock);

      $display("Scanned %0d bytes with %0d predicted matches over %0d register settings,",
               bytes_checked, hits_checked, settings_count);
      $display("under no idling, sender gaps, receiver stalls and both mixed.");
      if (fail_count == 0 && waiting_results == 0) begin
         $display("byte_pattern_stream_matcher test passed");
      end else begin
         $display("byte_pattern_stream_matcher test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bpsm_pkg.sv
rtl/bpsm_cell.sv
rtl/byte_pattern_stream_matcher.sv
dv/pattern_match_checker.sv
dv/tb_byte_pattern_stream_matcher.sv
